// ===== sv/brpm_pkg.sv =====
// ----------------------------------------------------------------------------
// brpm_pkg
// Request codes and status codes shared by the byte ring pointer manager.
// ----------------------------------------------------------------------------
package brpm_pkg;

    typedef enum logic [1:0] {
        REQ_WR_PEEK   = 2'd0,
        REQ_WR_COMMIT = 2'd1,
        REQ_RD_PEEK   = 2'd2,
        REQ_RD_COMMIT = 2'd3
    } req_type_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

endpackage

// ===== sv/brpm_cfg.sv =====
// ----------------------------------------------------------------------------
// brpm_cfg
// APB register slice holding ring_size; clamps it to the legal range and
// pulses a ring clear on every write to it.
// ----------------------------------------------------------------------------
module brpm_cfg
    import brpm_pkg::*;
#(
    parameter longint unsigned MAX_RING_BYTES = 65536,
    parameter int CW = 17,
    parameter int DW = 32,
    parameter int AW = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [DW-1:0] pwdata,
    output logic [DW-1:0] prdata,
    output logic          pready,
    output logic [CW-1:0] ring_size,
    output logic          ring_clear
);

    localparam logic [CW-1:0] MAX_SIZE = CW'(MAX_RING_BYTES);

    logic [CW-1:0] ring_size_reg;
    logic [CW-1:0] eff_size_reg;
    logic [CW-1:0] wr_value;
    logic [CW-1:0] eff_size_next;
    logic          wr_strobe;

    assign pready     = 1'b1;
    assign wr_strobe  = psel && penable && pwrite && (paddr == '0);
    assign wr_value   = pwdata[CW-1:0];
    assign ring_clear = wr_strobe;
    assign ring_size  = eff_size_reg;
    assign prdata     = (paddr == '0) ? DW'(ring_size_reg) : '0;

    // Zero means one byte; anything past the maximum is held at the maximum
    always_comb
    begin
        if (wr_value == '0)
        begin
            eff_size_next = CW'(1);
        end
        else if (wr_value > MAX_SIZE)
        begin
            eff_size_next = MAX_SIZE;
        end
        else
        begin
            eff_size_next = wr_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= MAX_SIZE;
            eff_size_reg  <= MAX_SIZE;
        end
        else if (wr_strobe)
        begin
            ring_size_reg <= wr_value;
            eff_size_reg  <= eff_size_next;
        end
    end

endmodule

// ===== sv/brpm_engine.sv =====
// ----------------------------------------------------------------------------
// brpm_engine
// Pointer state and the single-pass request logic: segment grants for peeks,
// pointer advance and count checks for commits, registered result.
// ----------------------------------------------------------------------------
module brpm_engine
    import brpm_pkg::*;
#(
    parameter int PW = 16,
    parameter int CW = 17
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  req_type_t     item_type,
    input  logic [CW-1:0] item_req,
    input  logic [CW-1:0] ring_size,
    input  logic          ring_clear,
    output logic          done,
    output logic [PW-1:0] first_offset,
    output logic [CW-1:0] first_length,
    output logic [CW-1:0] wrap_length,
    output logic [CW-1:0] granted_total,
    output logic          status,
    output logic [CW-1:0] bytes_available,
    output logic          ring_full
);

    logic [PW-1:0] rd_reg;
    logic [PW-1:0] wr_reg;
    logic          full_reg;
    logic [PW-1:0] rd_next;
    logic [PW-1:0] wr_next;
    logic          full_next;

    logic          done_reg;
    logic [PW-1:0] off_reg;
    logic [CW-1:0] len1_reg;
    logic [CW-1:0] len2_reg;
    logic [CW-1:0] total_reg;
    logic          status_reg;
    logic [CW-1:0] avail_reg;
    logic          full_out_reg;

    logic [CW-1:0] rd_ext;
    logic [CW-1:0] wr_ext;
    logic          empty;
    logic [CW-1:0] avail;
    logic [CW-1:0] space;
    logic          grant;
    logic [PW-1:0] off;
    logic [CW-1:0] lim1;
    logic [CW-1:0] lim2;
    logic [CW-1:0] len1;
    logic [CW-1:0] rest;
    logic [CW-1:0] len2;
    logic [CW:0]   adv_sum;
    logic [CW:0]   adv_wrap;
    logic [PW-1:0] adv_ptr;
    logic          status_next;
    logic [CW-1:0] avail_next;

    assign rd_ext = CW'(rd_reg);
    assign wr_ext = CW'(wr_reg);
    assign empty  = (rd_reg == wr_reg) && !full_reg;

    always_comb
    begin
        if (empty)
        begin
            avail = '0;
        end
        else if (rd_reg < wr_reg)
        begin
            avail = wr_ext - rd_ext;
        end
        else
        begin
            avail = ring_size - rd_ext + wr_ext;
        end
    end

    assign space = ring_size - avail;

    // Segment limits: first segment from the pointer, second from offset zero
    always_comb
    begin
        grant = 1'b0;
        off   = '0;
        lim1  = '0;
        lim2  = '0;
        case (item_type)
            REQ_WR_PEEK:
            begin
                grant = !full_reg && (item_req != '0);
                off   = wr_reg;
                if (rd_reg <= wr_reg)
                begin
                    lim1 = ring_size - wr_ext;
                    lim2 = rd_ext;
                end
                else
                begin
                    lim1 = rd_ext - wr_ext;
                end
            end
            REQ_RD_PEEK:
            begin
                grant = !empty && (item_req != '0);
                off   = rd_reg;
                if (rd_reg < wr_reg)
                begin
                    lim1 = wr_ext - rd_ext;
                end
                else
                begin
                    lim1 = ring_size - rd_ext;
                    lim2 = wr_ext;
                end
            end
            default:
            begin
                grant = 1'b0;
            end
        endcase
    end

    assign len1 = !grant ? '0 : ((item_req < lim1) ? item_req : lim1);
    assign rest = item_req - len1;
    assign len2 = !grant ? '0 : ((rest < lim2) ? rest : lim2);

    // Pointer advance modulo the ring size
    assign adv_sum  = (item_type == REQ_WR_COMMIT) ? ((CW+1)'(wr_reg) + (CW+1)'(item_req))
                                                   : ((CW+1)'(rd_reg) + (CW+1)'(item_req));
    assign adv_wrap = (adv_sum >= (CW+1)'(ring_size)) ? (adv_sum - (CW+1)'(ring_size))
                                                      : adv_sum;
    assign adv_ptr  = adv_wrap[PW-1:0];

    always_comb
    begin
        rd_next     = rd_reg;
        wr_next     = wr_reg;
        full_next   = full_reg;
        status_next = STATUS_OK;
        avail_next  = avail;
        case (item_type)
            REQ_WR_COMMIT:
            begin
                if (item_req != '0)
                begin
                    if (item_req > space)
                    begin
                        status_next = STATUS_BAD;
                    end
                    else
                    begin
                        wr_next    = adv_ptr;
                        full_next  = (adv_ptr == rd_reg);
                        avail_next = avail + item_req;
                    end
                end
            end
            REQ_RD_COMMIT:
            begin
                if (item_req != '0)
                begin
                    if (item_req > avail)
                    begin
                        status_next = STATUS_BAD;
                    end
                    else
                    begin
                        full_next  = 1'b0;
                        avail_next = avail - item_req;
                        // drained: park both pointers at zero
                        if (adv_ptr == wr_reg)
                        begin
                            rd_next = '0;
                            wr_next = '0;
                        end
                        else
                        begin
                            rd_next = adv_ptr;
                        end
                    end
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= '0;
            wr_reg   <= '0;
            full_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= item_valid;
            if (ring_clear)
            begin
                rd_reg   <= '0;
                wr_reg   <= '0;
                full_reg <= 1'b0;
            end
            else if (item_valid)
            begin
                rd_reg   <= rd_next;
                wr_reg   <= wr_next;
                full_reg <= full_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            // report offset zero when nothing is granted
            off_reg      <= grant ? off : '0;
            len1_reg     <= len1;
            len2_reg     <= len2;
            total_reg    <= len1 + len2;
            status_reg   <= status_next;
            avail_reg    <= avail_next;
            full_out_reg <= full_next;
        end
    end

    assign done            = done_reg;
    assign first_offset    = off_reg;
    assign first_length    = len1_reg;
    assign wrap_length     = len2_reg;
    assign granted_total   = total_reg;
    assign status          = status_reg;
    assign bytes_available = avail_reg;
    assign ring_full       = full_out_reg;

    a_full_ptrs_equal: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (rd_reg == wr_reg))
        else $error("full flag set with unequal pointers");

    a_ptrs_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_ext < ring_size) && (wr_ext < ring_size))
        else $error("pointer outside the ring");

    a_bad_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !ring_clear && (status_next == STATUS_BAD))
        |=> ($stable(rd_reg) && $stable(wr_reg) && $stable(full_reg)))
        else $error("rejected commit moved the pointers");

    a_full_avail: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && full_out_reg) |-> (avail_reg == ring_size))
        else $error("full ring reports short byte count");

endmodule

// ===== sv/byte_ring_pointer_manager.sv =====
// ----------------------------------------------------------------------------
// byte_ring_pointer_manager
// Read/write pointer and full-flag manager for a byte ring of programmable
// size, with peek (segment grant) and commit (pointer advance) requests.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Fields
//  request   start / busy          req_type, requested_bytes
//  result    done (one cycle)      first_offset, first_length, wrap_length,
//                                  granted_total, status, bytes_available,
//                                  ring_full
//  config    APB psel/penable      ring_size at byte address 0
//
//  One request per cycle; start is registered into item_valid_reg, which done_reg then registers.
//  The pointer update of one request is a single compare-and-subtract pass,
//  so back-to-back requests see each other's state without stalls.
//  busy stays low; the result is never held off by the receiver.
//  Reset empties the ring and sets ring_size to MAX_RING_BYTES; a ring_size
//  write empties the ring as well.
// ----------------------------------------------------------------------------
module byte_ring_pointer_manager
    import brpm_pkg::*;
#(
    parameter longint unsigned MAX_RING_BYTES = 65536,
    parameter int PW = $clog2(MAX_RING_BYTES),
    parameter int CW = $clog2(MAX_RING_BYTES + 1),
    parameter int DW = (CW > 32) ? 64 : 32,
    parameter int AW = (DW == 64) ? 3 : 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [1:0]    req_type,
    input  logic [CW-1:0] requested_bytes,
    output logic          done,
    output logic [PW-1:0] first_offset,
    output logic [CW-1:0] first_length,
    output logic [CW-1:0] wrap_length,
    output logic [CW-1:0] granted_total,
    output logic          status,
    output logic [CW-1:0] bytes_available,
    output logic          ring_full,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [DW-1:0] pwdata,
    output logic [DW-1:0] prdata,
    output logic          pready
);

    logic          item_valid_reg;
    req_type_t     item_type_reg;
    logic [CW-1:0] item_req_reg;
    logic [CW-1:0] ring_size;
    logic          ring_clear;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_type_reg <= req_type_t'(req_type);
            item_req_reg  <= requested_bytes;
        end
    end

    brpm_cfg #(
        .MAX_RING_BYTES (MAX_RING_BYTES),
        .CW             (CW),
        .DW             (DW),
        .AW             (AW)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .ring_size  (ring_size),
        .ring_clear (ring_clear)
    );

    brpm_engine #(
        .PW (PW),
        .CW (CW)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid_reg),
        .item_type       (item_type_reg),
        .item_req        (item_req_reg),
        .ring_size       (ring_size),
        .ring_clear      (ring_clear),
        .done            (done),
        .first_offset    (first_offset),
        .first_length    (first_length),
        .wrap_length     (wrap_length),
        .granted_total   (granted_total),
        .status          (status),
        .bytes_available (bytes_available),
        .ring_full       (ring_full)
    );

endmodule

// ===== tb/sv/brpm_checker.sv =====
// ----------------------------------------------------------------------------
// brpm_checker
// Watches the request, result and APB channels of the byte ring pointer
// manager. It keeps its own copy of the ring pointers and the ring size,
// predicts every result and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module brpm_checker
    import brpm_pkg::*;
#(
    parameter int unsigned MAX_RING_BYTES = 65536,
    parameter logic [1:0]  RING_SIZE_ADDR = 2'd0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  req_type,
    input  logic [16:0] requested_bytes,
    input  logic        done,
    input  logic [15:0] first_offset,
    input  logic [16:0] first_length,
    input  logic [16:0] wrap_length,
    input  logic [16:0] granted_total,
    input  logic        status,
    input  logic [16:0] bytes_available,
    input  logic        ring_full,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] offset;
        logic [16:0] len1;
        logic [16:0] len2;
        logic [16:0] total;
        logic        bad;
        logic [16:0] avail;
        logic        full;
    } ring_grant_t;

    logic [15:0]  rd_ptr;
    logic [15:0]  wr_ptr;
    logic         full_q;
    int unsigned  ring_bytes;
    ring_grant_t  grant_q[$];
    ring_grant_t  want;
    int           results_seen;
    int unsigned  new_size;

    initial errors = 0;

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val)
            report($sformatf("result %0d %s: expected %0d, got %0d",
                             results_seen, name, exp_val, got_val));
    endtask

    function automatic int unsigned smaller(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic int unsigned used_bytes();
        if (rd_ptr == wr_ptr && !full_q)
            return 0;
        if (rd_ptr < wr_ptr)
            return wr_ptr - rd_ptr;
        return (ring_bytes - rd_ptr) + wr_ptr;
    endfunction

    // Predict one request and advance the ring state.
    function automatic ring_grant_t advance_ring(input req_type_t op, input logic [16:0] count);
        int unsigned rd;
        int unsigned wr;
        int unsigned req;
        int unsigned l1;
        int unsigned l2;
        int unsigned space;
        int unsigned nxt;
        bit          empty;
        ring_grant_t g;
        rd    = rd_ptr;
        wr    = wr_ptr;
        req   = count;
        l1    = 0;
        l2    = 0;
        g     = '0;
        empty = (rd == wr) && !full_q;
        case (op)
            REQ_WR_PEEK:
            begin
                if (!full_q && req != 0)
                begin
                    g.offset = wr_ptr;
                    if (rd <= wr)
                    begin
                        l1 = smaller(req, ring_bytes - wr);
                        l2 = smaller(req - l1, rd);
                    end
                    else
                        l1 = smaller(req, rd - wr);
                end
            end
            REQ_RD_PEEK:
            begin
                if (!empty && req != 0)
                begin
                    g.offset = rd_ptr;
                    if (rd < wr)
                        l1 = smaller(req, wr - rd);
                    else
                    begin
                        l1 = smaller(req, ring_bytes - rd);
                        l2 = smaller(req - l1, wr);
                    end
                end
            end
            REQ_WR_COMMIT:
            begin
                if (req != 0)
                begin
                    space = full_q ? 0 : ((rd <= wr) ? (ring_bytes - wr) + rd : rd - wr);
                    if (full_q || req > space)
                        g.bad = STATUS_BAD;
                    else
                    begin
                        nxt = wr + req;
                        if (nxt >= ring_bytes)
                            nxt -= ring_bytes;
                        wr_ptr = nxt[15:0];
                        if (nxt == rd)
                            full_q = 1'b1;
                    end
                end
            end
            default:
            begin
                if (req != 0)
                begin
                    if (empty || req > used_bytes())
                        g.bad = STATUS_BAD;
                    else
                    begin
                        nxt = rd + req;
                        if (nxt >= ring_bytes)
                            nxt -= ring_bytes;
                        full_q = 1'b0;
                        // drained ring snaps both pointers home
                        if (nxt == wr)
                        begin
                            nxt    = 0;
                            wr_ptr = '0;
                        end
                        rd_ptr = nxt[15:0];
                    end
                end
            end
        endcase
        g.len1  = l1[16:0];
        g.len2  = l2[16:0];
        g.total = 17'(l1 + l2);
        g.avail = 17'(used_bytes());
        g.full  = full_q;
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr       = '0;
            wr_ptr       = '0;
            full_q       = 1'b0;
            ring_bytes   = MAX_RING_BYTES;
            results_seen = 0;
            grant_q.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (grant_q.size() == 0)
                    report($sformatf("result %0d arrived with no request outstanding",
                                     results_seen));
                else
                begin
                    want = grant_q.pop_front();
                    check_field("first_offset", want.offset, first_offset);
                    check_field("first_length", want.len1, first_length);
                    check_field("wrap_length", want.len2, wrap_length);
                    check_field("granted_total", want.total, granted_total);
                    check_field("status", want.bad, status);
                    check_field("bytes_available", want.avail, bytes_available);
                    check_field("ring_full", want.full, ring_full);
                end
                results_seen++;
            end
            if (start && !busy)
                grant_q.push_back(advance_ring(req_type_t'(req_type), requested_bytes));
            // a size write clamps the value and empties the ring
            if (psel && penable && pwrite && pready && paddr == RING_SIZE_ADDR)
            begin
                new_size   = pwdata[16:0];
                ring_bytes = (new_size == 0) ? 1 :
                             (new_size > MAX_RING_BYTES) ? MAX_RING_BYTES : new_size;
                rd_ptr     = '0;
                wr_ptr     = '0;
                full_q     = 1'b0;
            end
            pending <= grant_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_byte_ring_pointer_manager.sv =====
// ----------------------------------------------------------------------------
// tb_byte_ring_pointer_manager
// Drives peek and commit requests and ring size writes into the byte ring
// pointer manager: a directed opening over empty, full and wrapped rings,
// then random traffic over a range of ring sizes, with random start gaps (none in the quiet phase).
// Checking is done by brpm_checker; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_byte_ring_pointer_manager
    import brpm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_RING_BYTES = 65536;
    localparam logic [1:0]  RING_SIZE_ADDR = 2'd0;
    localparam int          NUM_PHASES     = 14;
    localparam int          QUIET_PHASE    = 4;
    localparam int unsigned PHASE_SIZES [NUM_PHASES] = '{
        65536, 1, 2, 3, 65536, 7, 16, 100, 257, 4096, 65535, 0, 131071, 32'hFFFE_0005
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_type = REQ_WR_PEEK;
    logic [16:0] requested_bytes = '0;
    logic        done;
    logic [15:0] first_offset;
    logic [16:0] first_length;
    logic [16:0] wrap_length;
    logic [16:0] granted_total;
    logic        status;
    logic [16:0] bytes_available;
    logic        ring_full;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = RING_SIZE_ADDR;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;

    bit          no_idle = 1'b0;
    int unsigned cur_size = MAX_RING_BYTES;
    int          op_count [4] = '{0, 0, 0, 0};
    int          size_writes = 0;

    byte_ring_pointer_manager uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .requested_bytes (requested_bytes),
        .done            (done),
        .first_offset    (first_offset),
        .first_length    (first_length),
        .wrap_length     (wrap_length),
        .granted_total   (granted_total),
        .status          (status),
        .bytes_available (bytes_available),
        .ring_full       (ring_full),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    brpm_checker #(
        .MAX_RING_BYTES (MAX_RING_BYTES),
        .RING_SIZE_ADDR (RING_SIZE_ADDR)
    ) ring_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .requested_bytes (requested_bytes),
        .done            (done),
        .first_offset    (first_offset),
        .first_length    (first_length),
        .wrap_length     (wrap_length),
        .granted_total   (granted_total),
        .status          (status),
        .bytes_available (bytes_available),
        .ring_full       (ring_full),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .errors          (errors),
        .pending         (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

    // Present one request and hold it until the block takes the transaction.
    task automatic send_req(input req_type_t op, input logic [16:0] count);
        while (!no_idle && $urandom_range(99) < 7)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        req_type        <= op;
        requested_bytes <= count;
        start           <= 1'b1;
        op_count[op]++;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drain outstanding results, then write ring_size over APB.
    task automatic program_ring(input int unsigned value);
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (3) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RING_SIZE_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_size = (value[16:0] == 0) ? 1 :
                   (value[16:0] > MAX_RING_BYTES) ? MAX_RING_BYTES : value[16:0];
        size_writes++;
    endtask

    // Byte counts mostly scaled to the ring so commits land, wrap and fill.
    function automatic logic [16:0] pick_count(input int unsigned size);
        int unsigned r;
        int unsigned c;
        r = $urandom_range(19);
        if (r < 2)
            c = 0;
        else if (r < 10)
            c = $urandom_range(size / 4 + 1, 1);
        else if (r < 14)
            c = $urandom_range(size, 1);
        else if (r < 16)
            c = size;
        else if (r < 17)
            c = (size + 1 > MAX_RING_BYTES) ? MAX_RING_BYTES : size + 1;
        else
            c = $urandom_range(MAX_RING_BYTES, 0);
        return c[16:0];
    endfunction

    initial
    begin
        int n_items;
        int guard;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring at reset size
        send_req(REQ_WR_PEEK, 17'd0);
        send_req(REQ_RD_PEEK, 17'd10);
        send_req(REQ_RD_COMMIT, 17'd0);
        send_req(REQ_RD_COMMIT, 17'd5);
        send_req(REQ_WR_COMMIT, 17'd0);
        // fill to the brim and drain in one transaction
        send_req(REQ_WR_PEEK, 17'd65536);
        send_req(REQ_WR_COMMIT, 17'd65536);
        send_req(REQ_WR_PEEK, 17'd10);
        send_req(REQ_WR_COMMIT, 17'd1);
        send_req(REQ_WR_COMMIT, 17'd0);
        send_req(REQ_RD_PEEK, 17'd65536);
        send_req(REQ_RD_COMMIT, 17'd65536);
        // wrapped segments
        send_req(REQ_WR_COMMIT, 17'd100);
        send_req(REQ_RD_COMMIT, 17'd40);
        send_req(REQ_RD_COMMIT, 17'd61);
        send_req(REQ_WR_PEEK, 17'd65536);
        send_req(REQ_WR_COMMIT, 17'd65477);
        send_req(REQ_WR_COMMIT, 17'd65476);
        send_req(REQ_RD_PEEK, 17'd65536);
        send_req(REQ_RD_COMMIT, 17'd65496);
        send_req(REQ_RD_PEEK, 17'd100);
        // zero size is taken as a one-byte ring
        program_ring(0);
        send_req(REQ_WR_PEEK, 17'd5);
        send_req(REQ_WR_COMMIT, 17'd1);
        send_req(REQ_RD_COMMIT, 17'd1);
        // one above the maximum clamps to the maximum
        program_ring(MAX_RING_BYTES + 1);
        send_req(REQ_WR_PEEK, 17'd65536);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            program_ring(PHASE_SIZES[p]);
            no_idle = (p == QUIET_PHASE);
            n_items = no_idle ? 250 : $urandom_range(95, 75);
            for (int i = 0; i < n_items; i++)
                send_req(req_type_t'($urandom_range(3)), pick_count(cur_size));
        end
        no_idle = 1'b0;

        start <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (pending != 0 && guard < 200);
        repeat (5) @(posedge clk);

        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        $display("Covered %0d requests over %0d ring size writes", op_count.sum(), size_writes);
        $display("  write peek %0d, write commit %0d, read peek %0d, read commit %0d",
                 op_count[REQ_WR_PEEK], op_count[REQ_WR_COMMIT],
                 op_count[REQ_RD_PEEK], op_count[REQ_RD_COMMIT]);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== byte_ring_pointer_manager.f =====
sv/brpm_pkg.sv
sv/brpm_cfg.sv
sv/brpm_engine.sv
sv/byte_ring_pointer_manager.sv
tb/sv/brpm_checker.sv
tb/sv/tb_byte_ring_pointer_manager.sv
